/* rtl/assert_macros.svh */
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SPQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("spq assertion failed");

// Next-cycle implication, disabled during reset
`define SPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("spq assertion failed");

`endif

/* rtl/spq_pkg.sv */
package spq_pkg;

    // Store geometry and field widths
    localparam int DEPTH     = 16;
    localparam int PAY_W     = 32;
    localparam int PRIO_W    = 16;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int OUT_CNT_W = 5;

    // Request action codes
    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Operation issued by the controller to the datapath
    typedef enum logic [2:0] {
        OP_NONE      = 3'd0,
        OP_INSERT    = 3'd1,
        OP_REMOVE    = 3'd2,
        OP_REJ_FULL  = 3'd3,
        OP_REJ_EMPTY = 3'd4
    } t_op;

    typedef struct packed {
        logic load;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic action;
        logic full;
        logic empty;
    } t_stat;

endpackage

/* rtl/spq_if.sv */
// Request channel
interface spq_req_if;
    logic                                valid;
    logic                                ready;
    logic                                action;
    logic [spq_pkg::PAY_W-1:0]           payload_in;
    logic signed [spq_pkg::PRIO_W-1:0]   prio_in;

    modport source (output valid, action, payload_in, prio_in, input ready);
    modport sink   (input valid, action, payload_in, prio_in, output ready);
endinterface

// Result channel
interface spq_res_if;
    logic                              valid;
    logic                              ready;
    logic [spq_pkg::PAY_W-1:0]         payload_out;
    logic [1:0]                        status;
    logic                              is_empty;
    logic [spq_pkg::OUT_CNT_W-1:0]     entry_count;

    modport source (output valid, payload_out, status, is_empty, entry_count, input ready);
    modport sink   (input valid, payload_out, status, is_empty, entry_count, output ready);
endinterface

/* rtl/spq_ctrl.sv */
module spq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_out_ready,
    input  spq_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output logic           o_out_valid,
    output spq_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;

    // Sequencing: latch request, then update store once the result slot is free
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd.load = 1'b0;
        o_cmd.op   = spq_pkg::OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_slot_free) begin
                    if (i_stat.action == spq_pkg::ACT_ENQ) begin
                        o_cmd.op = i_stat.full ? spq_pkg::OP_REJ_FULL : spq_pkg::OP_INSERT;
                    end else begin
                        o_cmd.op = i_stat.empty ? spq_pkg::OP_REJ_EMPTY : spq_pkg::OP_REMOVE;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Result valid: set on completion, cleared when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.op != spq_pkg::OP_NONE) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* rtl/spq_dpath.sv */
module spq_dpath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  spq_pkg::t_cmd                     i_cmd,
    input  logic                              i_action,
    input  logic [spq_pkg::PAY_W-1:0]         i_payload,
    input  logic signed [spq_pkg::PRIO_W-1:0] i_prio,
    output spq_pkg::t_stat                    o_stat,
    output logic [spq_pkg::PAY_W-1:0]         o_payload_out,
    output logic [1:0]                        o_status,
    output logic                              o_is_empty,
    output logic [spq_pkg::OUT_CNT_W-1:0]     o_count
);

    localparam int D = spq_pkg::DEPTH;

    // Latched request
    logic                              r_act;
    logic [spq_pkg::PAY_W-1:0]         r_pay_in;
    logic signed [spq_pkg::PRIO_W-1:0] r_prio_in;

    // Sorted store, head at index 0
    logic [spq_pkg::PAY_W-1:0]         r_pay  [D];
    logic signed [spq_pkg::PRIO_W-1:0] r_prio [D];
    logic [spq_pkg::PAY_W-1:0]         n_pay  [D];
    logic signed [spq_pkg::PRIO_W-1:0] n_prio [D];
    logic [spq_pkg::CNT_W-1:0]         r_count, n_count;

    // Result register
    logic [spq_pkg::PAY_W-1:0]         r_res_pay, n_res_pay;
    spq_pkg::t_status                  r_res_st, n_res_st;

    logic [D-1:0] w_stay;

    // Entry i stays put on insert when it is valid and strictly ahead of the new priority
    always_comb begin
        for (int i = 0; i < D; i++) begin
            w_stay[i] = (spq_pkg::CNT_W'(i) < r_count) && !(r_prio_in <= r_prio[i]);
        end
    end

    // Next store contents and result
    always_comb begin
        n_pay     = r_pay;
        n_prio    = r_prio;
        n_count   = r_count;
        n_res_pay = r_res_pay;
        n_res_st  = r_res_st;
        unique case (i_cmd.op)
            spq_pkg::OP_INSERT: begin
                // head slot: keep, or take the new entry
                if (!w_stay[0]) begin
                    n_pay[0]  = r_pay_in;
                    n_prio[0] = r_prio_in;
                end
                for (int i = 1; i < D; i++) begin
                    if (w_stay[i]) begin
                        n_pay[i]  = r_pay[i];
                        n_prio[i] = r_prio[i];
                    end else if (w_stay[i-1]) begin
                        n_pay[i]  = r_pay_in;
                        n_prio[i] = r_prio_in;
                    end else begin
                        n_pay[i]  = r_pay[i-1];
                        n_prio[i] = r_prio[i-1];
                    end
                end
                n_count   = r_count + spq_pkg::CNT_W'(1);
                n_res_pay = '0;
                n_res_st  = spq_pkg::ST_OK;
            end
            spq_pkg::OP_REMOVE: begin
                for (int i = 0; i < D - 1; i++) begin
                    n_pay[i]  = r_pay[i+1];
                    n_prio[i] = r_prio[i+1];
                end
                n_count   = r_count - spq_pkg::CNT_W'(1);
                n_res_pay = r_pay[0];
                n_res_st  = spq_pkg::ST_OK;
            end
            spq_pkg::OP_REJ_FULL: begin
                n_res_pay = '0;
                n_res_st  = spq_pkg::ST_FULL;
            end
            spq_pkg::OP_REJ_EMPTY: begin
                n_res_pay = '0;
                n_res_st  = spq_pkg::ST_EMPTY;
            end
            default: ;
        endcase
    end

    // Control state: entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Payload registers: store, request latch and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act     <= i_action;
            r_pay_in  <= i_payload;
            r_prio_in <= i_prio;
        end
        r_pay     <= n_pay;
        r_prio    <= n_prio;
        r_res_pay <= n_res_pay;
        r_res_st  <= n_res_st;
    end

    assign o_stat.action = r_act;
    assign o_stat.full   = (r_count == spq_pkg::CNT_W'(D));
    assign o_stat.empty  = (r_count == '0);

    assign o_payload_out = r_res_pay;
    assign o_status      = r_res_st;
    assign o_is_empty    = (r_count == '0);
    assign o_count       = spq_pkg::OUT_CNT_W'(r_count);

endmodule

/* rtl/sorted_priority_queue.sv */
// A request is latched on acceptance; the sorted shift store (parallel
// per-entry compares) then updates and the result is registered, to be
// taken from then on. No new request is accepted until that update is done.
// A pending result that is not taken holds the update cycle until it is.
// Reset (i_rst_n low, synchronous): clears entry count, controller state and
// result valid; stored entries are not cleared and are never read unwritten.
`include "assert_macros.svh"

module sorted_priority_queue (
    input  logic       i_clk,
    input  logic       i_rst_n,
    spq_req_if.sink    i_req,
    spq_res_if.source  o_res
);

    spq_pkg::t_cmd  w_cmd;
    spq_pkg::t_stat w_stat;

    logic                            w_res_full;
    logic                            w_res_empty;
    logic                            w_req_acc;
    logic [spq_pkg::OUT_CNT_W-1:0]   w_full_cnt;

    // Controller
    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_res.ready),
        .i_stat      (w_stat),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_res.valid),
        .o_cmd       (w_cmd)
    );

    // Datapath
    spq_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_action      (i_req.action),
        .i_payload     (i_req.payload_in),
        .i_prio        (i_req.prio_in),
        .o_stat        (w_stat),
        .o_payload_out (o_res.payload_out),
        .o_status      (o_res.status),
        .o_is_empty    (o_res.is_empty),
        .o_count       (o_res.entry_count)
    );

    // Checks
    assign w_res_full  = o_res.valid && (o_res.status == spq_pkg::ST_FULL);
    assign w_res_empty = o_res.valid && (o_res.status == spq_pkg::ST_EMPTY);
    assign w_req_acc   = i_req.valid && i_req.ready;
    assign w_full_cnt  = spq_pkg::OUT_CNT_W'(spq_pkg::DEPTH);

    `SPQ_ASSERT_NOW(a_full_count, w_res_full, o_res.entry_count == w_full_cnt)
    `SPQ_ASSERT_NOW(a_empty_deq, w_res_empty, o_res.is_empty && o_res.payload_out == '0)
    `SPQ_ASSERT_NOW(a_empty_flag, o_res.valid, o_res.is_empty == (o_res.entry_count == '0))
    `SPQ_ASSERT_NEXT(a_no_accept_busy, w_req_acc, !i_req.ready)

endmodule

/* dv/sorted_priority_queue_tb.sv */
`timescale 1ns / 1ps

module sorted_priority_queue_tb;

    localparam int RAND_ITEMS  = 750;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 90;
    localparam int DRAIN_WAIT  = 8;

    // One expected result
    typedef struct packed {
        logic [spq_pkg::PAY_W-1:0]     payload;
        spq_pkg::t_status              status;
        logic                          empty;
        logic [spq_pkg::OUT_CNT_W-1:0] count;
    } t_res_item;

    // Shadow copy of the sorted store and the results it owes
    class t_spq_shadow;
        logic [spq_pkg::PAY_W-1:0]         slot_payload [spq_pkg::DEPTH];
        logic signed [spq_pkg::PRIO_W-1:0] slot_prio    [spq_pkg::DEPTH];
        int unsigned                       held;
        t_res_item                         owed [$];
        int unsigned                       mismatches;

        function new();
            held       = 0;
            mismatches = 0;
        endfunction

        function int unsigned pending();
            return owed.size();
        endfunction

        // Apply an accepted request and queue the result it causes
        function void note_request(logic act, logic [spq_pkg::PAY_W-1:0] pay,
                                   logic signed [spq_pkg::PRIO_W-1:0] prio);
            t_res_item   r;
            int unsigned pos;
            int unsigned i;
            r.payload = '0;
            r.status  = spq_pkg::ST_OK;
            if (act == spq_pkg::ACT_ENQ) begin
                if (held >= spq_pkg::DEPTH) begin
                    r.status = spq_pkg::ST_FULL;
                end else begin
                    // goes before the first entry with priority >= its own
                    pos = 0;
                    while (pos < held && prio > slot_prio[pos]) pos++;
                    for (i = held; i > pos; i--) begin
                        slot_payload[i] = slot_payload[i-1];
                        slot_prio[i]    = slot_prio[i-1];
                    end
                    slot_payload[pos] = pay;
                    slot_prio[pos]    = prio;
                    held++;
                end
            end else begin
                if (held == 0) begin
                    r.status = spq_pkg::ST_EMPTY;
                end else begin
                    r.payload = slot_payload[0];
                    for (i = 1; i < held; i++) begin
                        slot_payload[i-1] = slot_payload[i];
                        slot_prio[i-1]    = slot_prio[i];
                    end
                    held--;
                end
            end
            r.empty = (held == 0);
            r.count = spq_pkg::OUT_CNT_W'(held);
            owed.push_back(r);
        endfunction

        function void report(string field, logic [spq_pkg::PAY_W-1:0] exp_v,
                             logic [spq_pkg::PAY_W-1:0] act_v);
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, exp_v, act_v);
        endfunction

        // Compare an accepted result with the oldest owed one
        function void check_result(t_res_item got);
            t_res_item e;
            if (owed.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual 0x%0h", $time, got);
                return;
            end
            e = owed[0];
            owed.delete(0);
            if (got.payload !== e.payload) report("payload_out", e.payload, got.payload);
            if (got.status !== e.status)   report("status", e.status, got.status);
            if (got.empty !== e.empty)     report("is_empty", e.empty, got.empty);
            if (got.count !== e.count)     report("entry_count", e.count, got.count);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   no_idle;
    bit   hold_ask;

    spq_req_if req ();
    spq_res_if res ();

    t_spq_shadow shadow = new();

    sorted_priority_queue u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_res   (res)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Mostly small priorities so that ties are common, plus the extremes and full-range values
    function automatic logic signed [spq_pkg::PRIO_W-1:0] pick_prio();
        int tmp;
        case ($urandom_range(9)) inside
            0:       tmp = -32768;
            1:       tmp = 32767;
            [2:3]:   tmp = int'($signed(spq_pkg::PRIO_W'($urandom)));
            default: begin
                tmp = $urandom_range(0, 9);
                tmp = tmp - 5;
            end
        endcase
        return spq_pkg::PRIO_W'(tmp);
    endfunction

    // Offer one request, with random idle cycles ahead of it unless no_idle is set
    task automatic send_req(input logic act, input logic [spq_pkg::PAY_W-1:0] pay,
                            input logic signed [spq_pkg::PRIO_W-1:0] prio);
        while (!no_idle && $urandom_range(99) < 23) begin
            req.valid <= 1'b0;
            @(posedge i_clk);
        end
        req.valid      <= 1'b1;
        req.action     <= act;
        req.payload_in <= pay;
        req.prio_in    <= prio;
        do @(posedge i_clk); while (!req.ready);
        shadow.note_request(act, pay, prio);
    endtask

    // Result side: check, then pick ready for the next cycle
    initial begin
        int        hold_left;
        t_res_item got;
        hold_left = 0;
        res.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (res.valid && res.ready) begin
                got.payload = res.payload_out;
                got.status  = spq_pkg::t_status'(res.status);
                got.empty   = res.is_empty;
                got.count   = res.entry_count;
                shadow.check_result(got);
            end
            if (hold_ask) begin
                hold_ask  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res.ready <= 1'b0;
            end else begin
                res.ready <= no_idle || ($urandom_range(99) >= 23);
            end
        end
    end

    // Watchdog: cycles with nothing accepted on either channel
    initial begin
        int stall_cycles;
        stall_cycles = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((req.valid && req.ready) || (res.valid && res.ready)) stall_cycles = 0;
            else stall_cycles++;
        end
        $display("[sorted_priority_queue] ERROR");
        $finish;
    end

    // Stimulus
    initial begin
        logic signed [spq_pkg::PRIO_W-1:0] dir_prio [16];
        int                                enq_bias;
        int                                blk_left;
        int                                n;
        logic                              act;

        dir_prio = '{-32768, 32767, 0, -1, 1, 0, 0, -32768,
                     32767, 100, -100, 5, 5, -2, 7, 3};

        no_idle        = 1'b0;
        hold_ask       = 1'b0;
        i_rst_n        = 1'b0;
        req.valid      = 1'b0;
        req.action     = spq_pkg::ACT_ENQ;
        req.payload_in = '0;
        req.prio_in    = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: dequeue while empty, fill with extremes and ties,
        // enqueue while full (would be the head if kept), partial drain
        send_req(spq_pkg::ACT_DEQ, 32'hFFFF_FFFF, 16'sh7FFF);
        for (n = 0; n < 16; n++) begin
            if (n == 0)      send_req(spq_pkg::ACT_ENQ, 32'h0000_0000, dir_prio[n]);
            else if (n == 1) send_req(spq_pkg::ACT_ENQ, 32'hFFFF_FFFF, dir_prio[n]);
            else             send_req(spq_pkg::ACT_ENQ, 32'h1000_0000 + n, dir_prio[n]);
        end
        send_req(spq_pkg::ACT_ENQ, 32'hDEAD_BEEF, -16'sd32768);
        repeat (6) send_req(spq_pkg::ACT_DEQ, '0, '0);

        // Random: blocks with varying enqueue bias sweep the store
        // between empty and full
        blk_left = 0;
        enq_bias = 50;
        for (n = 0; n < RAND_ITEMS; n++) begin
            if (blk_left == 0) begin
                blk_left = $urandom_range(15, 60);
                case ($urandom_range(3))
                    0:       enq_bias = 85;
                    1:       enq_bias = 20;
                    default: enq_bias = 50;
                endcase
            end
            blk_left--;

            // long receiver hold-off while requests keep coming
            if (n == 200) hold_ask = 1'b1;
            // let everything drain before going on
            if (n == 450) begin
                req.valid <= 1'b0;
                @(posedge i_clk);
                while (shadow.pending() != 0) @(posedge i_clk);
            end
            if (n == 500) no_idle = 1'b1;
            if (n == 620) no_idle = 1'b0;

            act = ($urandom_range(99) < enq_bias) ? spq_pkg::ACT_ENQ : spq_pkg::ACT_DEQ;
            send_req(act, $urandom, pick_prio());
        end

        req.valid <= 1'b0;
        @(posedge i_clk);
        while (shadow.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (shadow.mismatches == 0 && shadow.pending() == 0) begin
            $display("[sorted_priority_queue] OK");
        end else begin
            $display("[sorted_priority_queue] ERROR");
        end
        $finish;
    end

endmodule
